// ===== src/sng_pkg.sv =====
// Shared types and constants for the stereo noise gate.
// No dependencies; used by every module in src.
package sng_pkg;

  localparam int SampleW = 16;
  localparam int EnvW    = 17;
  localparam int CoefW   = 16;
  localparam int IdxW    = 2;

  localparam logic [EnvW-1:0] EnvUnity = 17'h10000;

  localparam logic [CoefW-1:0] ThrReset     = 16'd0;
  localparam logic [CoefW-1:0] AttackReset  = 16'd1351;
  localparam logic [CoefW-1:0] ReleaseReset = 16'd27;

  typedef enum logic [IdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_GAIN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // sequencer strobes to the envelope unit and the lanes
  typedef struct packed {
    logic step_en;
    logic upd_en;
    logic gain_en;
  } sng_ctrl_t;

endpackage

// ===== src/stereo_noise_gate.sv =====
// Stereo noise gate top level: stream ports, config registers, sequencer.
// Depends on sng_pkg, sng_lane and sng_env.
//
// Usage:
//   in_*  : one stereo frame per word; tdata = {right, left}, tuser = right present.
//   out_* : one word per frame; tdata = {pad, gate level, gated right, gated left}.
//   cfg_* : register writes (0 threshold, 1 attack, 2 release); always ready,
//           other indexes are dropped. Write only while no frame is in flight.
// Timing:
//   A frame is taken into the sample registers, then the envelope step multiply,
//   the envelope update and the two lane gain multiplies each take a register
//   stage before the result is loaded into the output word. One frame is
//   processed at a time: a new frame is taken only once the sequencer has walked
//   the dependent envelope then gain steps and handed the result to the output.
//   The output word sits in its own register, so the next frame is accepted and
//   worked on while the previous result waits; if the receiver stalls, the
//   finished frame waits in the final step until the output register frees.
// Reset (rst_n low, synchronous): envelope goes to zero (gate closed),
//   registers return to defaults, output valid drops.
module stereo_noise_gate
  import sng_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic            in_tuser,   // [0] right_present
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [55:0]     out_tdata,  // [15:0] gated_left, [31:16] gated_right,
                                      // [48:32] gate_level, [55:49] zero
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [15:0]     cfg_data
);

  state_t state_r, state_nxt;
  sng_ctrl_t ctrl;

  logic [CoefW-1:0] thr_r, attack_r, release_r;
  logic signed [SampleW-1:0] left_r, right_r;
  logic [SampleW-1:0] left_mag, right_mag;
  logic signed [SampleW-1:0] gain_l, gain_r;
  logic [EnvW-1:0] env;
  logic out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r;
  logic in_fire, out_load;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= ThrReset;
      attack_r  <= AttackReset;
      release_r <= ReleaseReset;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: thr_r     <= cfg_data;
        REG_ATTACK:    attack_r  <= cfg_data;
        REG_RELEASE:   release_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // absent right channel enters as a zero sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_r  <= in_tdata[15:0];
      right_r <= in_tuser ? in_tdata[31:16] : 16'sd0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctrl.step_en = 1'b0;
    ctrl.upd_en  = 1'b0;
    ctrl.gain_en = 1'b0;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_STEP;
      ST_STEP: begin
        ctrl.step_en = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd_en = 1'b1;
        state_nxt   = ST_GAIN;
      end
      ST_GAIN: begin
        ctrl.gain_en = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  sng_lane u_lane_l (
    .clk    (clk),
    .sample (left_r),
    .env    (env),
    .ctrl   (ctrl),
    .mag    (left_mag),
    .gain_r (gain_l)
  );

  sng_lane u_lane_r (
    .clk    (clk),
    .sample (right_r),
    .env    (env),
    .ctrl   (ctrl),
    .mag    (right_mag),
    .gain_r (gain_r)
  );

  sng_env u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .left_mag  (left_mag),
    .right_mag (right_mag),
    .threshold (thr_r),
    .attack    (attack_r),
    .release_c (release_r),
    .env_r     (env)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, env, gain_r, gain_l};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/sng_lane.sv =====
// One channel lane: sample magnitude for the peak detector and the
// registered sample-times-envelope gain multiply. Depends on sng_pkg.
module sng_lane
  import sng_pkg::*;
(
  input  logic                      clk,
  input  logic signed [SampleW-1:0] sample,
  input  logic        [EnvW-1:0]    env,
  input  sng_ctrl_t                 ctrl,
  output logic        [SampleW-1:0] mag,
  output logic signed [SampleW-1:0] gain_r
);

  logic signed [SampleW+EnvW:0] prod;
  logic signed [SampleW-1:0]    gain_nxt;

  // most negative sample wraps to 0x8000, read unsigned as 32768
  assign mag = sample[SampleW-1] ? (~sample + 16'd1) : sample;

  // arithmetic shift gives floor division by 65536
  assign prod     = sample * $signed({1'b0, env});
  assign gain_nxt = prod[SampleW+15:16];

  always_ff @(posedge clk) begin
    if (ctrl.gain_en) begin
      gain_r <= gain_nxt;
    end
  end

endmodule

// ===== src/sng_env.sv =====
// Merge stage: peak of the two lane magnitudes, gate decision and the
// attack/release envelope follower. Depends on sng_pkg.
module sng_env
  import sng_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sng_ctrl_t          ctrl,
  input  logic [SampleW-1:0] left_mag,
  input  logic [SampleW-1:0] right_mag,
  input  logic [CoefW-1:0]   threshold,
  input  logic [CoefW-1:0]   attack,
  input  logic [CoefW-1:0]   release_c,
  output logic [EnvW-1:0]    env_r
);

  logic [SampleW-1:0]    peak;
  logic                  open;
  logic                  rising;
  logic [EnvW-1:0]       delta;
  logic [CoefW-1:0]      coef;
  logic [CoefW+EnvW-1:0] prod;
  logic [EnvW-1:0]       step_r, step_nxt;
  logic                  up_r, up_nxt;
  logic [EnvW-1:0]       env_nxt;

  always_comb begin
    peak   = (left_mag > right_mag) ? left_mag : right_mag;
    open   = (peak >= threshold);
    rising = open && (env_r != EnvUnity);
    if (rising) begin
      delta = EnvUnity - env_r;
      coef  = attack;
    end else begin
      // open at unity gives delta zero
      delta = open ? (EnvUnity - env_r) : env_r;
      coef  = release_c;
    end
    prod     = {{EnvW{1'b0}}, coef} * {{CoefW{1'b0}}, delta};
    step_nxt = prod[CoefW+EnvW-1:16];
    up_nxt   = rising;
    env_nxt  = up_r ? (env_r + step_r) : (env_r - step_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_en) begin
      step_r <= step_nxt;
      up_r   <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (ctrl.upd_en) begin
      env_r <= env_nxt;
    end
  end

endmodule

// ===== src/sng_checker.sv =====
// Port-level checks for stereo_noise_gate, bound to the top level.
// Depends on sng_pkg for widths.
module sng_checker
  import sng_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [55:0]     out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // one frame in flight: no accept right after an accept
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a frame is in flight");

  // envelope never passes unity, pad bits stay zero
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48:32] <= EnvUnity) && (out_tdata[55:49] == 7'd0))
    else $error("gate level out of range");

  // input stays not ready while an accepted frame is worked on
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("frame finished too early");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind stereo_noise_gate sng_checker u_sng_checker (.*);
